[rtl/lpg_pkg.sv]
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants for the LED pattern generator core.
// ----------------------------------------------------------------------------
package lpg_pkg;

	// input word: tick or pattern select
	typedef struct packed {
		logic       command;
		logic [3:0] pattern_number;
	} lpg_item_t;

	// result word
	typedef struct packed {
		logic [7:0] level;
		logic [2:0] current_pattern;
		logic       bad_pattern;
	} lpg_result_t;

	// configuration register file contents
	typedef struct packed {
		logic [7:0]  max_level;
		logic [6:0]  breathe_step;
		logic [10:0] blink_on_ms;
		logic [10:0] blink_off_ms;
		logic [7:0]  dim_level;
		logic [11:0] dim_delay_ms;
	} lpg_cfg_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int CNT_W      = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LEVEL    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BREATHE_STEP = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_ON     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_OFF    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_LEVEL    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_DELAY    = 3'd5;

	// register reset values
	localparam logic [7:0]  RST_MAX_LEVEL    = 8'd255;
	localparam logic [6:0]  RST_BREATHE_STEP = 7'd5;
	localparam logic [10:0] RST_BLINK_ON     = 11'd500;
	localparam logic [10:0] RST_BLINK_OFF    = 11'd500;
	localparam logic [7:0]  RST_DIM_LEVEL    = 8'd51;
	localparam logic [11:0] RST_DIM_DELAY    = 12'd1100;

	// breathing segment lengths in ms
	localparam logic [CNT_W-1:0] HOLD_OFF_MS = 12'd30;
	localparam logic [CNT_W-1:0] RISE_MS     = 12'd45;
	localparam logic [CNT_W-1:0] PAUSE_MS    = 12'd20;
	localparam logic [CNT_W-1:0] FALL_MS     = 12'd31;

	// breathing phases
	localparam logic [1:0] PH_OFF   = 2'd0;
	localparam logic [1:0] PH_UP    = 2'd1;
	localparam logic [1:0] PH_PAUSE = 2'd2;
	localparam logic [1:0] PH_DOWN  = 2'd3;

	// blink phases
	localparam logic [1:0] BL_IDLE = 2'd0;
	localparam logic [1:0] BL_ON   = 2'd1;
	localparam logic [1:0] BL_OFF  = 2'd2;

	// pattern numbers
	localparam logic [2:0] PAT_NONE    = 3'd0;
	localparam logic [2:0] PAT_SOLID   = 3'd1;
	localparam logic [2:0] PAT_OFF     = 3'd2;
	localparam logic [2:0] PAT_BREATHE = 3'd3;
	localparam logic [2:0] PAT_BLINK   = 3'd4;
	localparam logic [2:0] PAT_ONCE    = 3'd5;
	localparam logic [2:0] PAT_DIM     = 3'd6;

endpackage

[rtl/led_pattern_generator_core.sv]
// ----------------------------------------------------------------------------
// led_pattern_generator_core
// LED pattern generator: ticks and pattern commands in, LED level out.
// ----------------------------------------------------------------------------
// Takes one word per clock when the result side keeps up. A word is held in
// an input register, the pattern state is updated from it by one pass of
// add/compare/clamp logic, and the result lands in an output register once
// any earlier result there is taken. The input register frees as soon as its
// word moves to the output register, so a new word is taken while a finished
// result still waits. cfg_ready is always high; the user must write registers
// only while no word is in flight; the block itself does not enforce this.
module led_pattern_generator_core
	import lpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  item_valid,
	output logic                  item_ready,
	input  lpg_item_t             item,

	output logic                  result_valid,
	input  logic                  result_ready,
	output lpg_result_t           result,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	lpg_cfg_t    cfg;
	lpg_item_t   item_s1;
	logic        valid_s1;
	logic        advance;
	lpg_result_t next_result;
	lpg_result_t result_q;
	logic        result_valid_q;

	assign cfg_ready  = 1'b1;
	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	lpg_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	lpg_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (next_result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= next_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[rtl/lpg_cfg.sv]
// ----------------------------------------------------------------------------
// lpg_cfg
// Configuration register file, written through a write-enable port.
// ----------------------------------------------------------------------------
module lpg_cfg
	import lpg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output lpg_cfg_t              cfg
);

	lpg_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_level    <= RST_MAX_LEVEL;
			cfg_q.breathe_step <= RST_BREATHE_STEP;
			cfg_q.blink_on_ms  <= RST_BLINK_ON;
			cfg_q.blink_off_ms <= RST_BLINK_OFF;
			cfg_q.dim_level    <= RST_DIM_LEVEL;
			cfg_q.dim_delay_ms <= RST_DIM_DELAY;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MAX_LEVEL:    cfg_q.max_level    <= wr_data[7:0];
				REG_BREATHE_STEP: cfg_q.breathe_step <= wr_data[6:0];
				REG_BLINK_ON:     cfg_q.blink_on_ms  <= wr_data[10:0];
				REG_BLINK_OFF:    cfg_q.blink_off_ms <= wr_data[10:0];
				REG_DIM_LEVEL:    cfg_q.dim_level    <= wr_data[7:0];
				REG_DIM_DELAY:    cfg_q.dim_delay_ms <= wr_data[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/lpg_engine.sv]
// ----------------------------------------------------------------------------
// lpg_engine
// Pattern state and next-state logic; one word is applied per fire.
// ----------------------------------------------------------------------------
module lpg_engine
	import lpg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  lpg_item_t   item,
	input  lpg_cfg_t    cfg,
	output lpg_result_t result
);

	logic [2:0]       active_q,  active_d;
	logic [1:0]       bphase_q,  bphase_d;
	logic             breath_q,  breath_d;
	logic [7:0]       level_q,   level_d;
	logic [CNT_W-1:0] step_cnt_q, step_cnt_d;
	logic [1:0]       blink_q,   blink_d;
	logic [CNT_W-1:0] dim_cnt_q, dim_cnt_d;
	logic             dim_pend_q, dim_pend_d;
	logic             bad;

	logic [8:0]       up_sum;
	logic [7:0]       dim_clamped;
	logic             pat_ok;
	logic [CNT_W-1:0] on_time;
	logic [CNT_W-1:0] off_time;

	assign up_sum      = {1'b0, level_q} + {2'b00, cfg.breathe_step};
	assign dim_clamped = (cfg.dim_level < cfg.max_level) ? cfg.dim_level : cfg.max_level;
	assign pat_ok      = (item.pattern_number >= {1'b0, PAT_SOLID}) &&
	                     (item.pattern_number <= {1'b0, PAT_DIM});
	assign on_time     = {1'b0, cfg.blink_on_ms};
	assign off_time    = {1'b0, cfg.blink_off_ms};

	always_comb begin
		active_d   = active_q;
		bphase_d   = bphase_q;
		breath_d   = breath_q;
		level_d    = level_q;
		step_cnt_d = step_cnt_q;
		blink_d    = blink_q;
		dim_cnt_d  = dim_cnt_q;
		dim_pend_d = dim_pend_q;
		bad        = 1'b0;

		if (item.command) begin
			breath_d   = 1'b0;
			dim_pend_d = 1'b0;
			dim_cnt_d  = '0;
			if (pat_ok) begin
				blink_d    = BL_IDLE;
				step_cnt_d = '0;
				active_d   = item.pattern_number[2:0];
				case (item.pattern_number[2:0])
					PAT_SOLID: level_d = cfg.max_level;
					PAT_OFF:   level_d = '0;
					PAT_BREATHE: begin
						// first breathing step from the off phase
						level_d    = '0;
						bphase_d   = PH_UP;
						step_cnt_d = HOLD_OFF_MS;
						breath_d   = 1'b1;
					end
					default: begin
						level_d    = cfg.max_level;
						blink_d    = BL_ON;
						step_cnt_d = on_time;
						if (item.pattern_number[2:0] == PAT_DIM) begin
							dim_pend_d = 1'b1;
							dim_cnt_d  = cfg.dim_delay_ms;
						end
					end
				endcase
			end else begin
				bad = 1'b1;
			end
		end else begin
			if (breath_q) begin
				if (step_cnt_q <= 12'd1) begin
					unique case (bphase_q)
						PH_OFF: begin
							level_d    = '0;
							bphase_d   = PH_UP;
							step_cnt_d = HOLD_OFF_MS;
						end
						PH_UP: begin
							if (up_sum > {1'b0, cfg.max_level}) begin
								level_d  = cfg.max_level;
								bphase_d = PH_PAUSE;
							end else begin
								level_d = up_sum[7:0];
							end
							step_cnt_d = RISE_MS;
						end
						PH_PAUSE: begin
							level_d    = cfg.max_level;
							bphase_d   = PH_DOWN;
							step_cnt_d = PAUSE_MS;
						end
						default: begin
							if (level_q < {1'b0, cfg.breathe_step}) begin
								level_d  = '0;
								bphase_d = PH_OFF;
							end else begin
								level_d = level_q - {1'b0, cfg.breathe_step};
							end
							step_cnt_d = FALL_MS;
						end
					endcase
				end else begin
					step_cnt_d = step_cnt_q - 12'd1;
				end
			end else if (blink_q != BL_IDLE) begin
				if (step_cnt_q <= 12'd1) begin
					if (blink_q == BL_ON) begin
						level_d    = '0;
						blink_d    = BL_OFF;
						step_cnt_d = off_time;
					end else if (blink_q == BL_OFF && active_q == PAT_BLINK) begin
						level_d    = cfg.max_level;
						blink_d    = BL_ON;
						step_cnt_d = on_time;
					end else begin
						blink_d    = BL_IDLE;
						step_cnt_d = '0;
					end
				end else begin
					step_cnt_d = step_cnt_q - 12'd1;
				end
			end
			// dim expiry overrides any blink in progress
			if (dim_pend_q) begin
				if (dim_cnt_q <= 12'd1) begin
					dim_pend_d = 1'b0;
					dim_cnt_d  = '0;
					blink_d    = BL_IDLE;
					step_cnt_d = '0;
					level_d    = dim_clamped;
				end else begin
					dim_cnt_d = dim_cnt_q - 12'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= PAT_NONE;
			bphase_q   <= PH_OFF;
			breath_q   <= 1'b0;
			level_q    <= '0;
			step_cnt_q <= '0;
			blink_q    <= BL_IDLE;
			dim_cnt_q  <= '0;
			dim_pend_q <= 1'b0;
		end else if (fire) begin
			active_q   <= active_d;
			bphase_q   <= bphase_d;
			breath_q   <= breath_d;
			level_q    <= level_d;
			step_cnt_q <= step_cnt_d;
			blink_q    <= blink_d;
			dim_cnt_q  <= dim_cnt_d;
			dim_pend_q <= dim_pend_d;
		end
	end

	assign result.level           = level_d;
	assign result.current_pattern = active_d;
	assign result.bad_pattern     = bad;

`ifndef SYNTH
	a_breath_no_blink: assert property (@(posedge clk) disable iff (!arst_n)
		breath_q |-> (blink_q == BL_IDLE && active_q == PAT_BREATHE))
		else $error("breathing active alongside blink or wrong pattern");

	a_dim_only_p6: assert property (@(posedge clk) disable iff (!arst_n)
		dim_pend_q |-> (active_q == PAT_DIM))
		else $error("dim pending outside pattern six");

	a_blink_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		(blink_q != BL_IDLE) |->
		(active_q == PAT_BLINK || active_q == PAT_ONCE || active_q == PAT_DIM))
		else $error("blink running under a non-blink pattern");

	a_tick_not_bad: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !item.command) |-> !result.bad_pattern)
		else $error("bad pattern flagged on a tick");
`endif

endmodule
